### sv/integer_to_radix_digits_assert.svh
// Assertion macros for the integer to radix digits block.
// Included by the top level; expects a clock i_clk and reset i_rst_n in scope.
`ifndef INTEGER_TO_RADIX_DIGITS_ASSERT_SVH
`define INTEGER_TO_RADIX_DIGITS_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define ITRD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("integer_to_radix_digits assertion failed");

// Consequent checked in the cycle after the antecedent.
`define ITRD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("integer_to_radix_digits assertion failed");

`endif

### sv/itrd_pkg.sv
// Shared types, constants and the digit character function of the radix converter.
// No dependencies; used by all modules of the block.
package itrd_pkg;

    localparam int VALUE_W      = 32;
    localparam int DIGIT_W      = 6;
    localparam int CHAR_W       = 7;
    localparam int BIT_CNT_W    = 5;
    localparam int DIGIT_CAP    = 32;
    localparam int DIGIT_SLOTS_DEF = 32;

    localparam logic [DIGIT_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [DIGIT_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [DIGIT_W-1:0] RADIX_RESET = 6'd10;

    localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_A    = 7'h41;
    localparam logic [CHAR_W-1:0] CHAR_Z    = 7'h5A;

    typedef struct packed {
        logic load;
        logic div_step;
        logic store;
        logic rd;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic quot_zero;
        logic cnt_last;
        logic rd_zero;
        logic out_free;
    } t_status;

    function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] dx;
        dx = {1'b0, d};
        if (d < 6'd10) begin
            return CHAR_ZERO + dx;
        end
        return CHAR_A + dx - 7'd10;
    endfunction

endpackage

### sv/integer_to_radix_digits.sv
// Integer to radix digits converter, top level.
// Instantiates itrd_ctrl and itrd_dp; uses itrd_pkg and the assertion header.
//
// Usage: a signed 32-bit word arrives on the s_axis channel. Its magnitude is
// divided repeatedly by the base held in the radix register (written through
// i_cfg_wen / i_cfg_wdata, reset value 10; codes below 2 act as 2 and codes
// above 36 act as 36). The digits leave on the m_axis channel most significant
// first, one word per digit, with the sign on tuser and tlast on the final
// digit. A zero input gives the single digit 0.
// Sequence: each digit costs one bit-serial division and a store of the
// remainder; when the conversion is done, the remainder memory is read back
// and each digit is loaded into the output register in turn. A base-2 result
// has at most 32 digits.
// s_axis_tready is high only while the block is idle; the next input is taken
// while the last digit still waits in the output register.
// A stalled receiver simply holds the output register and pauses the readout.
// Reset (synchronous, active low) returns the controller to idle, empties the
// output register and restores the radix to 10. The remainder memory needs no
// clearing, since every entry is written before it is read.
module integer_to_radix_digits #(
    parameter int DIGIT_SLOTS = itrd_pkg::DIGIT_SLOTS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Configuration: the radix register.
    input  logic         i_cfg_wen,
    input  logic [5:0]   i_cfg_wdata,
    // Input words.
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,   // [31:0] value
    // Output words, one per digit.
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [15:0]  m_axis_tdata,   // [5:0] digit_value, [12:6] digit_char, [15:13] zero
    output logic         m_axis_tuser,   // [0] sign, set when the input was negative
    output logic         m_axis_tlast
);

    itrd_pkg::t_cmd                 cmd;
    itrd_pkg::t_status              status;
    logic [itrd_pkg::DIGIT_W-1:0]   digit;
    logic [itrd_pkg::CHAR_W-1:0]    dchar;

    itrd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    itrd_dp #(
        .DIGIT_SLOTS (DIGIT_SLOTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata),
        .i_value     (s_axis_tdata),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_digit     (digit),
        .o_char      (dchar),
        .o_neg       (m_axis_tuser),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {3'b000, dchar, digit};

    // Assertions.
`include "integer_to_radix_digits_assert.svh"

    // Once a word is taken the block is busy converting it.
    `ITRD_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // A presented digit always lies below the largest base.
    `ITRD_ASSERT_NOW(a_digit_range, m_axis_tvalid, m_axis_tdata[5:0] < itrd_pkg::RADIX_MAX)

    // The character always matches the digit value and never lies beyond Z.
    `ITRD_ASSERT_NOW(a_char_match, m_axis_tvalid,
        (m_axis_tdata[12:6] == itrd_pkg::digit_to_char(m_axis_tdata[5:0])) &&
        (m_axis_tdata[12:6] <= itrd_pkg::CHAR_Z))

endmodule

### sv/itrd_ctrl.sv
// Controller state machine of the radix converter.
// Depends on itrd_pkg; drives the datapath through t_cmd and reads t_status.
module itrd_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  itrd_pkg::t_status   i_status,
    output itrd_pkg::t_cmd      o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_DIV   = 5'b00010,
        S_STORE = 5'b00100,
        S_READ  = 5'b01000,
        S_LOAD  = 5'b10000
    } t_state;

    t_state                              r_state, n_state;
    logic [itrd_pkg::BIT_CNT_W-1:0]      r_bit_cnt, n_bit_cnt;

    always_comb begin
        n_state   = r_state;
        n_bit_cnt = r_bit_cnt;
        o_cmd     = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_bit_cnt  = '0;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_bit_cnt      = r_bit_cnt + 1'b1;
                if (r_bit_cnt == '1) begin
                    n_state = S_STORE;
                end
            end
            S_STORE: begin
                o_cmd.store = 1'b1;
                n_bit_cnt   = '0;
                if (i_status.quot_zero || i_status.cnt_last) begin
                    n_state = S_READ;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_LOAD;
            end
            S_LOAD: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = i_status.rd_zero ? S_IDLE : S_READ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_bit_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_bit_cnt <= n_bit_cnt;
        end
    end

endmodule

### sv/itrd_dp.sv
// Datapath of the radix converter: radix register, bit-serial divider,
// remainder memory and output register. Depends on itrd_pkg.
module itrd_dp #(
    parameter int DIGIT_SLOTS = itrd_pkg::DIGIT_SLOTS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wen,
    input  logic [itrd_pkg::DIGIT_W-1:0]        i_cfg_wdata,
    input  logic [itrd_pkg::VALUE_W-1:0]        i_value,
    input  itrd_pkg::t_cmd                      i_cmd,
    output itrd_pkg::t_status                   o_status,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [itrd_pkg::DIGIT_W-1:0]        o_digit,
    output logic [itrd_pkg::CHAR_W-1:0]         o_char,
    output logic                                o_neg,
    output logic                                o_last
);

    localparam int IDX_W = $clog2(DIGIT_SLOTS);
    localparam int CNT_W = $clog2(DIGIT_SLOTS + 1);
    localparam int LIMIT = (DIGIT_SLOTS < itrd_pkg::DIGIT_CAP) ? DIGIT_SLOTS
                                                                : itrd_pkg::DIGIT_CAP;

    logic [itrd_pkg::DIGIT_W-1:0]   r_radix;
    logic [itrd_pkg::DIGIT_W-1:0]   eff_radix;
    logic [itrd_pkg::VALUE_W-1:0]   r_quot;
    logic [itrd_pkg::DIGIT_W-1:0]   r_rem;
    logic [CNT_W-1:0]               r_count;
    logic [IDX_W-1:0]               r_rd_idx;
    logic [itrd_pkg::DIGIT_W-1:0]   r_rd_data;
    logic                           r_neg;
    logic                           r_out_valid;
    logic [itrd_pkg::DIGIT_W-1:0]   r_out_digit;
    logic [itrd_pkg::CHAR_W-1:0]    r_out_char;
    logic                           r_out_neg;
    logic                           r_out_last;
    logic [itrd_pkg::DIGIT_W-1:0]   r_mem [DIGIT_SLOTS];

    logic [itrd_pkg::VALUE_W-1:0]   magnitude;
    logic [itrd_pkg::DIGIT_W:0]     trial;
    logic [itrd_pkg::DIGIT_W:0]     diff;
    logic                           ge;

    // Out-of-range radix codes saturate to the nearest legal base.
    always_comb begin
        if (r_radix < itrd_pkg::RADIX_MIN) begin
            eff_radix = itrd_pkg::RADIX_MIN;
        end else if (r_radix > itrd_pkg::RADIX_MAX) begin
            eff_radix = itrd_pkg::RADIX_MAX;
        end else begin
            eff_radix = r_radix;
        end
    end

    assign magnitude = i_value[itrd_pkg::VALUE_W-1] ? (~i_value + 1'b1) : i_value;

    // One restoring division step: the dividend shifts out at the top while
    // quotient bits shift in at the bottom of the same register.
    assign trial = {r_rem, r_quot[itrd_pkg::VALUE_W-1]};
    assign diff  = trial - {1'b0, eff_radix};
    assign ge    = (trial >= {1'b0, eff_radix});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix     <= itrd_pkg::RADIX_RESET;
            r_quot      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wen) begin
                r_radix <= i_cfg_wdata;
            end
            if (i_cmd.load) begin
                r_quot  <= magnitude;
                r_count <= '0;
            end else if (i_cmd.div_step) begin
                r_quot  <= {r_quot[itrd_pkg::VALUE_W-2:0], ge};
            end else if (i_cmd.store) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rem <= '0;
            r_neg <= i_value[itrd_pkg::VALUE_W-1];
        end else if (i_cmd.div_step) begin
            r_rem <= ge ? diff[itrd_pkg::DIGIT_W-1:0] : trial[itrd_pkg::DIGIT_W-1:0];
        end else if (i_cmd.store) begin
            r_rem <= '0;
        end
        if (i_cmd.store) begin
            r_mem[r_count[IDX_W-1:0]] <= r_rem;
            r_rd_idx <= r_count[IDX_W-1:0];
        end else if (i_cmd.load_out) begin
            r_rd_idx <= r_rd_idx - 1'b1;
        end
        if (i_cmd.rd) begin
            r_rd_data <= r_mem[r_rd_idx];
        end
        if (i_cmd.load_out) begin
            r_out_digit <= r_rd_data;
            r_out_char  <= itrd_pkg::digit_to_char(r_rd_data);
            r_out_neg   <= r_neg;
            r_out_last  <= (r_rd_idx == '0);
        end
    end

    assign o_status.quot_zero = (r_quot == '0);
    assign o_status.cnt_last  = (r_count == CNT_W'(LIMIT - 1));
    assign o_status.rd_zero   = (r_rd_idx == '0);
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_digit     = r_out_digit;
    assign o_char      = r_out_char;
    assign o_neg       = r_out_neg;
    assign o_last      = r_out_last;

endmodule
